@@ rtl/lpwm_pkg.sv @@
`default_nettype none
package lpwm_pkg;

    localparam int REQ_W   = 2;
    localparam int CHAN_W  = 4;
    localparam int LEVEL_W = 8;
    localparam int MASK_W  = 11;

    typedef logic [LEVEL_W-1:0] level_t;
    typedef logic [MASK_W-1:0]  led_mask_t;
    typedef logic [CHAN_W-1:0]  chan_t;
    typedef logic [REQ_W-1:0]   req_code_t;

    localparam level_t LEVEL_DONE = '1;
    localparam level_t LEVEL_OFF  = '0;

    localparam req_code_t REQ_WRITE   = 2'd0;
    localparam req_code_t REQ_PERIOD  = 2'd1;
    localparam req_code_t REQ_COMPARE = 2'd2;

    // sequencer to scan unit
    typedef struct packed {
        logic clear;   // restart the running minimum
        logic step;    // fold the current channel in
        logic period;  // 1: period start pass, 0: compare pass
    } scan_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/lpwm_in_if.sv @@
`default_nettype none
interface lpwm_in_if;
    logic                  valid;
    logic                  ready;
    lpwm_pkg::req_code_t   req_type;
    lpwm_pkg::chan_t       channel;
    lpwm_pkg::level_t      intensity;

    modport source (output valid, req_type, channel, intensity, input ready);
    modport sink   (input valid, req_type, channel, intensity, output ready);
endinterface
`default_nettype wire

@@ rtl/lpwm_out_if.sv @@
`default_nettype none
interface lpwm_out_if;
    logic                  valid;
    logic                  ready;
    lpwm_pkg::led_mask_t   led_mask;
    lpwm_pkg::level_t      next_compare;

    modport source (output valid, led_mask, next_compare, input ready);
    modport sink   (input valid, led_mask, next_compare, output ready);
endinterface
`default_nettype wire

@@ rtl/lpwm_level_store.sv @@
`default_nettype none
module lpwm_level_store #(
    parameter int NUM_CHANNELS = 11,
    parameter int IDX_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              shadow_clr,
    input  wire logic              shadow_we,
    input  wire logic [IDX_W-1:0]  shadow_widx,
    input  wire lpwm_pkg::level_t  shadow_wdata,
    input  wire logic [IDX_W-1:0]  rd_idx,
    input  wire logic              active_we,
    input  wire lpwm_pkg::level_t  active_wdata,
    output lpwm_pkg::level_t       shadow_rd,
    output lpwm_pkg::level_t       active_rd
);
    import lpwm_pkg::*;

    level_t shadow_reg [NUM_CHANNELS];
    level_t active_reg [NUM_CHANNELS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                shadow_reg[i] <= LEVEL_OFF;
                active_reg[i] <= LEVEL_OFF;
            end
        end
        else
        begin
            if (shadow_clr)
            begin
                for (int i = 0; i < NUM_CHANNELS; i++)
                begin
                    shadow_reg[i] <= LEVEL_OFF;
                end
            end
            else if (shadow_we)
            begin
                shadow_reg[shadow_widx] <= shadow_wdata;
            end
            if (active_we)
            begin
                active_reg[rd_idx] <= active_wdata;
            end
        end
    end

    assign shadow_rd = shadow_reg[rd_idx];
    assign active_rd = active_reg[rd_idx];

endmodule
`default_nettype wire

@@ rtl/lpwm_scan_unit.sv @@
`default_nettype none
module lpwm_scan_unit (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lpwm_pkg::scan_ctrl_t ctrl,
    input  wire lpwm_pkg::level_t     shadow_rd,
    input  wire lpwm_pkg::level_t     active_rd,
    input  wire lpwm_pkg::level_t     pending,
    output lpwm_pkg::level_t          new_level,
    output logic                      bit_we,
    output logic                      bit_val,
    output lpwm_pkg::level_t          min_next
);
    import lpwm_pkg::*;

    level_t min_reg;
    logic   hit;

    always_comb
    begin
        hit = (active_rd == pending);
        if (ctrl.period)
        begin
            new_level = (shadow_rd != LEVEL_OFF) ? shadow_rd : LEVEL_DONE;
            bit_we    = 1'b1;
            bit_val   = (shadow_rd != LEVEL_OFF);
        end
        else
        begin
            new_level = hit ? LEVEL_DONE : active_rd;
            bit_we    = hit;
            bit_val   = 1'b0;
        end
        min_next = (new_level < min_reg) ? new_level : min_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= LEVEL_DONE;
        end
        else if (ctrl.clear)
        begin
            min_reg <= LEVEL_DONE;
        end
        else if (ctrl.step)
        begin
            min_reg <= min_next;
        end
    end

endmodule
`default_nettype wire

@@ rtl/multichannel_led_soft_pwm_scheduler_core.sv @@
`default_nettype none
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    req_type, channel, intensity
// out_ch    out  valid/ready    led_mask, next_compare
// cfg       in   cfg_wr_en      cfg_wr_data (fade_enable)
//
// A write item, and any item that leaves the channels alone, goes straight to the
// result load. A period start or compare match first scans the channels, one
// channel per cycle through the shared level compare unit, then loads the result.
// in_ch.ready is high only while the sequencer is idle; a finished result
// waits in the output register, and the sequencer holds until it can load it.
// Reset is asynchronous and needs no clearing pass.
module multichannel_led_soft_pwm_scheduler_core #(
    parameter int NUM_CHANNELS = 11
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lpwm_in_if.sink    in_ch,
    lpwm_out_if.source out_ch,
    input  wire logic  cfg_wr_en,
    input  wire logic  cfg_wr_data
);
    import lpwm_pkg::*;

    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_CHANNELS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [IDX_W-1:0]        idx_reg, idx_next;
    logic                    period_reg, period_next;
    logic [NUM_CHANNELS-1:0] lit_mask_reg, lit_mask_next;
    level_t                  pending_reg, pending_next;
    logic                    fade_reg, fade_next;
    logic                    out_valid_reg, out_valid_next;
    led_mask_t               out_mask_reg, out_mask_next;
    level_t                  out_cmp_reg, out_cmp_next;

    scan_ctrl_t              ctrl;
    logic                    in_fire;
    logic                    chan_ok;
    logic [IDX_W-1:0]        chan_idx;
    logic                    shadow_we;
    logic                    shadow_clr;
    level_t                  shadow_rd, active_rd, new_level, min_next;
    logic                    bit_we, bit_val;

    assign in_ch.ready         = (state_reg == S_IDLE);
    assign in_fire             = in_ch.valid && in_ch.ready;
    assign chan_ok             = (32'(in_ch.channel) < NUM_CHANNELS);
    assign chan_idx            = IDX_W'(in_ch.channel);
    assign shadow_clr          = cfg_wr_en && cfg_wr_data;

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.led_mask     = out_mask_reg;
    assign out_ch.next_compare = out_cmp_reg;

    lpwm_level_store #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .IDX_W        (IDX_W)
    ) u_store (
        .clk          (clk),
        .rst_n        (rst_n),
        .shadow_clr   (shadow_clr),
        .shadow_we    (shadow_we),
        .shadow_widx  (chan_idx),
        .shadow_wdata (in_ch.intensity),
        .rd_idx       (idx_reg),
        .active_we    (ctrl.step),
        .active_wdata (new_level),
        .shadow_rd    (shadow_rd),
        .active_rd    (active_rd)
    );

    lpwm_scan_unit u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .shadow_rd (shadow_rd),
        .active_rd (active_rd),
        .pending   (pending_reg),
        .new_level (new_level),
        .bit_we    (bit_we),
        .bit_val   (bit_val),
        .min_next  (min_next)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        period_next    = period_reg;
        lit_mask_next  = lit_mask_reg;
        pending_next   = pending_reg;
        fade_next      = fade_reg;
        out_valid_next = out_valid_reg;
        out_mask_next  = out_mask_reg;
        out_cmp_next   = out_cmp_reg;
        shadow_we      = 1'b0;
        ctrl.clear     = 1'b0;
        ctrl.step      = 1'b0;
        ctrl.period    = period_reg;

        if (out_ch.valid && out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EMIT;
                    idx_next   = '0;
                    case (in_ch.req_type)
                        REQ_WRITE:
                        begin
                            if (chan_ok)
                            begin
                                if (fade_reg)
                                begin
                                    shadow_we = 1'b1;
                                end
                                else
                                begin
                                    lit_mask_next[chan_idx] = (in_ch.intensity != LEVEL_OFF);
                                end
                            end
                        end
                        REQ_PERIOD:
                        begin
                            if (fade_reg)
                            begin
                                period_next = 1'b1;
                                ctrl.clear  = 1'b1;
                                state_next  = S_SCAN;
                            end
                        end
                        REQ_COMPARE:
                        begin
                            if (fade_reg && (pending_reg != LEVEL_DONE))
                            begin
                                period_next = 1'b0;
                                ctrl.clear  = 1'b1;
                                state_next  = S_SCAN;
                            end
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                ctrl.step = 1'b1;
                if (bit_we)
                begin
                    lit_mask_next[idx_reg] = bit_val;
                end
                if (idx_reg == IDX_LAST)
                begin
                    pending_next = min_next;
                    state_next   = S_EMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                // load the result once the output register is free
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_mask_next  = MASK_W'(lit_mask_reg);
                    out_cmp_next   = pending_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr_en)
        begin
            fade_next = cfg_wr_data;
            if (cfg_wr_data)
            begin
                pending_next = LEVEL_DONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            period_reg    <= 1'b0;
            lit_mask_reg  <= '0;
            pending_reg   <= LEVEL_DONE;
            fade_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_mask_reg  <= '0;
            out_cmp_reg   <= LEVEL_DONE;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            period_reg    <= period_next;
            lit_mask_reg  <= lit_mask_next;
            pending_reg   <= pending_next;
            fade_reg      <= fade_next;
            out_valid_reg <= out_valid_next;
            out_mask_reg  <= out_mask_next;
            out_cmp_reg   <= out_cmp_next;
        end
    end

    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (32'(idx_reg) < NUM_CHANNELS))
        else $error("scan index past last channel");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != S_IDLE))
        else $error("sequencer stayed idle after a transfer");

    a_pending_source: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(rst_n) && (pending_reg != $past(pending_reg))) |->
            ($past(state_reg == S_SCAN) || $past(cfg_wr_en)))
        else $error("pending compare changed outside a scan or config write");

    a_scan_ends_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_SCAN) && (idx_reg == IDX_LAST)) |=> (state_reg == S_EMIT))
        else $error("scan did not finish into result load");

endmodule
`default_nettype wire
